### hdl/json_byte_tokenizer_macros.svh
// assertion macros for the json byte tokenizer
`ifndef JSON_BYTE_TOKENIZER_MACROS_SVH
`define JSON_BYTE_TOKENIZER_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define JBT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("json tokenizer: same-cycle check failed");
// next-cycle implication, checked out of reset
`define JBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("json tokenizer: next-cycle check failed");
`else
`define JBT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define JBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/jbt_pkg.sv
// types, codes and character constants shared by the json byte tokenizer
`timescale 1ns / 1ps

package jbt_pkg;

    // result queue sizing
    localparam int MAX_RES   = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    // event codes of a result
    typedef enum logic [1:0] {
        EV_CONTENT = 2'd0,
        EV_TOKEN   = 2'd1,
        EV_ERROR   = 2'd2,
        EV_DONE    = 2'd3
    } t_event;

    // token kinds
    typedef enum logic [3:0] {
        TOK_LBRACE   = 4'd0,
        TOK_RBRACE   = 4'd1,
        TOK_LBRACKET = 4'd2,
        TOK_RBRACKET = 4'd3,
        TOK_COLON    = 4'd4,
        TOK_COMMA    = 4'd5,
        TOK_STRING   = 4'd6,
        TOK_INTEGER  = 4'd7,
        TOK_FLOAT    = 4'd8,
        TOK_TRUE     = 4'd9,
        TOK_FALSE    = 4'd10,
        TOK_NULL     = 4'd11
    } t_token;

    // scanner modes
    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_STR  = 6'b000010,
        MODE_ESC  = 6'b000100,
        MODE_INT  = 6'b001000,
        MODE_FRAC = 6'b010000,
        MODE_WORD = 6'b100000
    } t_mode;

    // word choices
    localparam logic [1:0] WORD_TRUE  = 2'd0;
    localparam logic [1:0] WORD_FALSE = 2'd1;
    localparam logic [1:0] WORD_NULL  = 2'd2;

    // characters with a special role
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       doc_end;
    } t_in;

    // result item
    typedef struct packed {
        logic [1:0] event_res;
        logic [3:0] token_kind;
        logic [7:0] content_byte;
        logic       is_fraction;
        logic       last_of_run;
    } t_out;

    // all results caused by one input byte
    typedef struct packed {
        logic [1:0]                count;
        t_out [MAX_RES-1:0]        res;
    } t_batch;

    // length of each keyword
    function automatic logic [2:0] word_len(input logic [1:0] ch);
        logic [2:0] len;
        case (ch)
            WORD_TRUE:  len = 3'd4;
            WORD_FALSE: len = 3'd5;
            WORD_NULL:  len = 3'd4;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    // expected character at a position of a keyword
    function automatic logic [7:0] word_char(input logic [1:0] ch, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (ch)
            WORD_TRUE: begin
                case (pos)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            WORD_FALSE: begin
                case (pos)
                    3'd0:    c = "f";
                    3'd1:    c = "a";
                    3'd2:    c = "l";
                    3'd3:    c = "s";
                    3'd4:    c = "e";
                    default: c = 8'h00;
                endcase
            end
            WORD_NULL: begin
                case (pos)
                    3'd0:    c = "n";
                    3'd1:    c = "u";
                    3'd2:    c = "l";
                    3'd3:    c = "l";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // build one result, last flag clear
    function automatic t_out make_res(input logic [1:0] ev, input logic [3:0] kind,
                                      input logic [7:0] val, input logic frac);
        t_out r;
        r.event_res    = ev;
        r.token_kind   = kind;
        r.content_byte = val;
        r.is_fraction  = frac;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

### hdl/jbt_scan.sv
// scanner state and per-byte result generation
`timescale 1ns / 1ps

module jbt_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  jbt_pkg::t_in   i_item,
    output jbt_pkg::t_batch o_batch
);

    jbt_pkg::t_mode r_mode, n_mode;
    logic [1:0]     r_wch, n_wch;
    logic [2:0]     r_wpos, n_wpos;
    logic           r_fnz, n_fnz;
    logic           r_err, n_err;

    // next state and the results of this byte
    always_comb begin
        logic [7:0]                        b;
        logic [1:0]                        k;
        logic                              do_idle;
        logic                              do_err;
        logic [7:0]                        esc;
        logic                              esc_ok;
        logic                              word_done;
        logic                              end_word_done;
        jbt_pkg::t_out [jbt_pkg::MAX_RES-1:0] res;

        b       = i_item.text_byte;
        n_mode  = r_mode;
        n_wch   = r_wch;
        n_wpos  = r_wpos;
        n_fnz   = r_fnz;
        n_err   = r_err;
        res     = '0;
        k       = 2'd0;
        do_idle = 1'b0;
        do_err  = 1'b0;
        esc     = 8'h00;
        esc_ok  = 1'b0;
        word_done = (r_wpos == jbt_pkg::word_len(r_wch)) && (r_wpos != 3'd0);

        if (!r_err) begin
            case (r_mode)
                jbt_pkg::MODE_STR: begin
                    if (b == jbt_pkg::CH_BSLASH) begin
                        n_mode = jbt_pkg::MODE_ESC;
                    end else if (b == jbt_pkg::CH_QUOTE) begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_TOKEN, jbt_pkg::TOK_STRING,
                                                   8'h00, 1'b0);
                        k = k + 2'd1;
                        n_mode = jbt_pkg::MODE_IDLE;
                    end else begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_CONTENT, jbt_pkg::TOK_STRING,
                                                   b, 1'b0);
                        k = k + 2'd1;
                    end
                end
                jbt_pkg::MODE_ESC: begin
                    // escape decode
                    case (b)
                        jbt_pkg::CH_QUOTE:  begin esc = jbt_pkg::CH_QUOTE;  esc_ok = 1'b1; end
                        jbt_pkg::CH_BSLASH: begin esc = jbt_pkg::CH_BSLASH; esc_ok = 1'b1; end
                        "b":                begin esc = jbt_pkg::CH_BS;     esc_ok = 1'b1; end
                        "f":                begin esc = jbt_pkg::CH_FF;     esc_ok = 1'b1; end
                        "n":                begin esc = jbt_pkg::CH_LF;     esc_ok = 1'b1; end
                        "t":                begin esc = jbt_pkg::CH_TAB;    esc_ok = 1'b1; end
                        default:            begin esc = 8'h00;              esc_ok = 1'b0; end
                    endcase
                    if (esc_ok) begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_CONTENT, jbt_pkg::TOK_STRING,
                                                   esc, 1'b0);
                        k = k + 2'd1;
                        n_mode = jbt_pkg::MODE_STR;
                    end else begin
                        do_err = 1'b1;
                    end
                end
                jbt_pkg::MODE_INT: begin
                    if (b inside {["0":"9"]}) begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_CONTENT, jbt_pkg::TOK_INTEGER,
                                                   b, 1'b0);
                        k = k + 2'd1;
                    end else if (b == ".") begin
                        n_mode = jbt_pkg::MODE_FRAC;
                    end else begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_TOKEN,
                                     r_fnz ? jbt_pkg::TOK_FLOAT : jbt_pkg::TOK_INTEGER,
                                     8'h00, 1'b0);
                        k = k + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                jbt_pkg::MODE_FRAC: begin
                    if (b inside {["0":"9"]}) begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_CONTENT, jbt_pkg::TOK_INTEGER,
                                                   b, 1'b1);
                        k = k + 2'd1;
                        if (b != "0") begin
                            n_fnz = 1'b1;
                        end
                    end else begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_TOKEN,
                                     r_fnz ? jbt_pkg::TOK_FLOAT : jbt_pkg::TOK_INTEGER,
                                     8'h00, 1'b0);
                        k = k + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                jbt_pkg::MODE_WORD: begin
                    if (b inside {"t", "r", "u", "e", "f", "a", "l", "s", "n"}) begin
                        if ((r_wpos < jbt_pkg::word_len(r_wch)) &&
                            (jbt_pkg::word_char(r_wch, r_wpos) == b)) begin
                            n_wpos = r_wpos + 3'd1;
                        end else begin
                            do_err = 1'b1;
                        end
                    end else if (word_done) begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_TOKEN,
                                     4'(jbt_pkg::TOK_TRUE) + {2'b00, r_wch}, 8'h00, 1'b0);
                        k = k + 2'd1;
                        do_idle = 1'b1;
                    end else begin
                        do_err = 1'b1;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            // byte seen from idle, also after a number or word closes
            if (do_idle) begin
                n_mode = jbt_pkg::MODE_IDLE;
                case (b)
                    jbt_pkg::CH_SPACE, jbt_pkg::CH_LF, jbt_pkg::CH_CR, jbt_pkg::CH_TAB: begin
                    end
                    "{": begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_TOKEN, jbt_pkg::TOK_LBRACE,
                                                   8'h00, 1'b0);
                        k = k + 2'd1;
                    end
                    "}": begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_TOKEN, jbt_pkg::TOK_RBRACE,
                                                   8'h00, 1'b0);
                        k = k + 2'd1;
                    end
                    "[": begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_TOKEN, jbt_pkg::TOK_LBRACKET,
                                                   8'h00, 1'b0);
                        k = k + 2'd1;
                    end
                    "]": begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_TOKEN, jbt_pkg::TOK_RBRACKET,
                                                   8'h00, 1'b0);
                        k = k + 2'd1;
                    end
                    ":": begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_TOKEN, jbt_pkg::TOK_COLON,
                                                   8'h00, 1'b0);
                        k = k + 2'd1;
                    end
                    ",": begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_TOKEN, jbt_pkg::TOK_COMMA,
                                                   8'h00, 1'b0);
                        k = k + 2'd1;
                    end
                    jbt_pkg::CH_QUOTE: begin
                        n_mode = jbt_pkg::MODE_STR;
                    end
                    "t": begin
                        n_wch  = jbt_pkg::WORD_TRUE;
                        n_wpos = 3'd1;
                        n_mode = jbt_pkg::MODE_WORD;
                    end
                    "f": begin
                        n_wch  = jbt_pkg::WORD_FALSE;
                        n_wpos = 3'd1;
                        n_mode = jbt_pkg::MODE_WORD;
                    end
                    "n": begin
                        n_wch  = jbt_pkg::WORD_NULL;
                        n_wpos = 3'd1;
                        n_mode = jbt_pkg::MODE_WORD;
                    end
                    default: begin
                        if ((b inside {["0":"9"]}) || (b == "-")) begin
                            res[k] = jbt_pkg::make_res(jbt_pkg::EV_CONTENT,
                                                       jbt_pkg::TOK_INTEGER, b, 1'b0);
                            k = k + 2'd1;
                            n_fnz  = 1'b0;
                            n_mode = jbt_pkg::MODE_INT;
                        end else begin
                            do_err = 1'b1;
                        end
                    end
                endcase
            end

            // fresh error latches and reports once
            if (do_err) begin
                n_err  = 1'b1;
                n_mode = jbt_pkg::MODE_IDLE;
                res[k] = jbt_pkg::make_res(jbt_pkg::EV_ERROR, jbt_pkg::TOK_LBRACE,
                                           8'h00, 1'b0);
                k = k + 2'd1;
            end
        end

        // end of document report and return to reset state
        end_word_done = (n_wpos == jbt_pkg::word_len(n_wch)) && (n_wpos != 3'd0);
        if (i_item.doc_end) begin
            if (r_err) begin
                res[k] = jbt_pkg::make_res(jbt_pkg::EV_ERROR, jbt_pkg::TOK_LBRACE,
                                           8'h00, 1'b0);
                k = k + 2'd1;
            end else if (!n_err) begin
                case (n_mode)
                    jbt_pkg::MODE_STR, jbt_pkg::MODE_ESC: begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_ERROR, jbt_pkg::TOK_LBRACE,
                                                   8'h00, 1'b0);
                        k = k + 2'd1;
                    end
                    jbt_pkg::MODE_INT, jbt_pkg::MODE_FRAC: begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_DONE,
                                     n_fnz ? jbt_pkg::TOK_FLOAT : jbt_pkg::TOK_INTEGER,
                                     8'h01, 1'b0);
                        k = k + 2'd1;
                    end
                    jbt_pkg::MODE_WORD: begin
                        if (end_word_done) begin
                            res[k] = jbt_pkg::make_res(jbt_pkg::EV_DONE,
                                         4'(jbt_pkg::TOK_TRUE) + {2'b00, n_wch},
                                         8'h01, 1'b0);
                        end else begin
                            res[k] = jbt_pkg::make_res(jbt_pkg::EV_ERROR,
                                         jbt_pkg::TOK_LBRACE, 8'h00, 1'b0);
                        end
                        k = k + 2'd1;
                    end
                    default: begin
                        res[k] = jbt_pkg::make_res(jbt_pkg::EV_DONE, jbt_pkg::TOK_LBRACE,
                                                   8'h00, 1'b0);
                        k = k + 2'd1;
                    end
                endcase
            end
            n_mode = jbt_pkg::MODE_IDLE;
            n_wch  = jbt_pkg::WORD_TRUE;
            n_wpos = 3'd0;
            n_fnz  = 1'b0;
            n_err  = 1'b0;
        end

        // flag the final result of this byte
        if (k != 2'd0) begin
            res[k - 2'd1].last_of_run = 1'b1;
        end

        o_batch.count = k;
        o_batch.res   = res;
    end

    // scanner state, advanced on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jbt_pkg::MODE_IDLE;
            r_wch  <= jbt_pkg::WORD_TRUE;
            r_wpos <= 3'd0;
            r_fnz  <= 1'b0;
            r_err  <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_wch  <= n_wch;
            r_wpos <= n_wpos;
            r_fnz  <= n_fnz;
            r_err  <= n_err;
        end
    end

endmodule

### hdl/jbt_rq.sv
// result queue: takes up to three results a cycle, hands out one
`timescale 1ns / 1ps

module jbt_rq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jbt_pkg::t_batch i_batch,
    input  logic            i_pop_ready,
    output logic            o_valid,
    output logic            o_room,
    output jbt_pkg::t_out   o_data
);

    jbt_pkg::t_out                  r_mem [jbt_pkg::Q_DEPTH];
    logic [jbt_pkg::Q_PTR_W-1:0]    r_wr, n_wr;
    logic [jbt_pkg::Q_PTR_W-1:0]    r_rd, n_rd;
    logic [jbt_pkg::Q_CNT_W-1:0]    r_count, n_count;
    logic                           w_pop;
    logic [jbt_pkg::Q_CNT_W-1:0]    w_add;

    // status and head of queue
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= jbt_pkg::Q_CNT_W'(jbt_pkg::Q_DEPTH - jbt_pkg::MAX_RES));
    assign o_data  = r_mem[r_rd];
    assign w_pop   = o_valid && i_pop_ready;
    assign w_add   = i_push ? jbt_pkg::Q_CNT_W'(i_batch.count) : '0;

    // pointer and fill arithmetic
    always_comb begin
        n_wr    = r_wr + jbt_pkg::Q_PTR_W'(w_add);
        n_rd    = w_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + w_add - (w_pop ? jbt_pkg::Q_CNT_W'(1) : '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // result storage, one slot per result of the batch
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < jbt_pkg::MAX_RES; j++) begin
            if (i_push && (j < int'(i_batch.count))) begin
                r_mem[r_wr + jbt_pkg::Q_PTR_W'(j)] <= i_batch.res[j];
            end
        end
    end

endmodule

### hdl/json_byte_tokenizer.sv
// top level of the streaming json byte tokenizer
`timescale 1ns / 1ps
`include "json_byte_tokenizer_macros.svh"

// Streaming JSON tokenizer: one text byte is taken per transfer and every
// byte is handled in the cycle it is taken, so a steady stream runs at one
// byte per clock while the output is ready. Each byte yields zero to three
// results (content bytes, token completions, an error or a document-end
// report); they enter a four-slot result queue and leave it one per cycle
// while the output is ready. The input side is ready while the queue
// holds at most one result, so single-result bytes flow back to back; a
// byte with two or three results holds the input while the queue drains,
// which sets the long-term rate. Errors stick until a document-end byte.
module json_byte_tokenizer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  jbt_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output jbt_pkg::t_out  o_out_data
);

    logic            w_take;
    jbt_pkg::t_batch w_batch;

    // input transfer
    assign w_take = i_in_valid && o_in_ready;

    // byte scanner
    jbt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (i_in_data),
        .o_batch (w_batch)
    );

    // result queue
    jbt_rq u_rq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_take),
        .i_batch     (w_batch),
        .i_pop_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_room      (o_in_ready),
        .o_data      (o_out_data)
    );

    // a document end always reports something
    `JBT_ASSERT_IMPLY(a_end_reports, i_clk, i_rst_n, w_take && i_in_data.doc_end, w_batch.count != 2'd0)
    // that report is queued for transfer by the next cycle
    `JBT_ASSERT_NEXT(a_end_queued, i_clk, i_rst_n, w_take && i_in_data.doc_end, o_out_valid)
    // input only stalls while results wait
    `JBT_ASSERT_IMPLY(a_stall_has_results, i_clk, i_rst_n, !o_in_ready, o_out_valid)

endmodule
